// ===== sv/gsm_pkg.sv =====
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared constants and the command/status types of the grid sync monitor.
// ----------------------------------------------------------------------------
package gsm_pkg;

  localparam int WINDOW_DEF = 200;

  localparam int FREQ_W  = 17;
  localparam int PHASE_W = 16;
  localparam int LOWLIM_W = 17;
  localparam int PLIM_W  = 15;
  localparam int CFG_W   = 17;
  localparam int TIME_W  = 32;

  localparam logic [FREQ_W-1:0] FREQ_MAX_MHZ = 17'd100000;
  localparam logic [FREQ_W-1:0] FREQ_LOW_RST = 17'd48000;
  localparam logic [FREQ_W-1:0] FREQ_HIGH_RST = 17'd52000;
  localparam logic [PLIM_W-1:0] PHASE_LIM_RST = 15'd2000;
  localparam logic [63:0] FREQ_SCALE = 64'd500000000;
  localparam logic [14:0] HALF_TURN_CDEG = 15'd18000;

  localparam logic [1:0] REG_FREQ_LOW  = 2'd0;
  localparam logic [1:0] REG_FREQ_HIGH = 2'd1;
  localparam logic [1:0] REG_PHASE_LIM = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the item, do edge detection, write ring
    logic rd_old;    // issue ring read of the oldest entry
    logic rd_new;    // issue ring read of the newest entry
    logic span;      // form span from the two reads
    logic div_start; // start a divide
    logic div_sel;   // 0: frequency divide, 1: remainder/phase divide
    logic mul;       // form the next dividend after a divide
    logic fin;       // compose the result
  } gsm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic full;
    logic span_zero;
  } gsm_sts_t;

endpackage

// ===== sv/grid_sync_monitor.sv =====
// The controller takes a new item only after the previous result has been accepted;
// once the ring is full and the span is nonzero, three passes of the shared
// bit-serial divider run for each item.
// Reset (rst_n low, synchronous) clears edge state, ring fill count and
// limits to their defaults; the ring memory itself is not cleared.
// ----------------------------------------------------------------------------
// grid_sync_monitor
// Mains frequency and phase meter with safety trip output.
// ----------------------------------------------------------------------------
module grid_sync_monitor #(
  parameter int WINDOW = gsm_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_freq_level,
  input  logic               in_phase_level,
  input  logic [31:0]        in_time_us,
  input  logic [31:0]        in_output_peak_us,
  input  logic               in_stop_button,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        out_freq_mhz,
  output logic               out_freq_valid,
  output logic signed [15:0] out_phase_cdeg,
  output logic               out_trip,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  gsm_pkg::gsm_cmd_t cmd;
  gsm_pkg::gsm_sts_t sts;

  // Controller: hold the item through its divides, advance on divider done.
  gsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  // Datapath: ring, span, divider, result register.
  gsm_dp #(.WINDOW(WINDOW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_freq_level(in_freq_level), .in_phase_level(in_phase_level),
    .in_time_us(in_time_us), .in_output_peak_us(in_output_peak_us),
    .in_stop_button(in_stop_button),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_freq_mhz(out_freq_mhz), .res_freq_valid(out_freq_valid),
    .res_phase_cdeg(out_phase_cdeg), .res_trip(out_trip)
  );

endmodule

// ===== sv/gsm_div.sv =====
// ----------------------------------------------------------------------------
// gsm_div
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// ----------------------------------------------------------------------------
module gsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);

  logic [63:0] q_r, q_nxt;
  logic [32:0] r_r, r_nxt;
  logic [31:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sh;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {r_r[31:0], q_r[63]};
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[31:0];

endmodule

// ===== sv/gsm_dp.sv =====
// ----------------------------------------------------------------------------
// gsm_dp
// Datapath: edge detection, midpoint ring, span, divider and trip compare.
// ----------------------------------------------------------------------------
module gsm_dp #(
  parameter int WINDOW = gsm_pkg::WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gsm_pkg::gsm_cmd_t    cmd,
  output gsm_pkg::gsm_sts_t    sts,
  input  logic                 in_freq_level,
  input  logic                 in_phase_level,
  input  logic [31:0]          in_time_us,
  input  logic [31:0]          in_output_peak_us,
  input  logic                 in_stop_button,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_data,
  output logic [16:0]          res_freq_mhz,
  output logic                 res_freq_valid,
  output logic signed [15:0]   res_phase_cdeg,
  output logic                 res_trip
);

  localparam int RING_LEN = WINDOW + 1;
  localparam int IDX_W = $clog2(RING_LEN);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_LEN - 1);
  localparam logic [63:0] FREQ_NUM = 64'(WINDOW) * gsm_pkg::FREQ_SCALE;

  logic [16:0] flow_r, fhigh_r;
  logic [14:0] plim_r;

  logic        pfl_r, ppl_r;
  logic [31:0] frise_r, prise_r, pmid_r;
  logic [IDX_W-1:0] head_r;
  logic [IDX_W:0]   count_r;
  logic [31:0] peak_r;
  logic        stop_r;
  logic [31:0] ring [RING_LEN];
  logic [31:0] rd_r, old_r, span_r;
  logic [16:0] freq_r;
  logic        neg_r;
  logic [31:0] mag_r;

  logic [31:0] fmid, pmid_new;
  logic        full;
  logic [31:0] pdiff;

  assign fmid = frise_r + ((in_time_us - frise_r) >> 1);
  assign pmid_new = prise_r + ((in_time_us - prise_r) >> 1);
  assign full = (count_r >= (IDX_W+1)'(RING_LEN));
  assign pdiff = pmid_r - peak_r;

  // divider
  logic        dv_done;
  logic [63:0] dv_q, dv_in;
  logic [31:0] dv_rem;

  always_comb begin
    if (!cmd.div_sel) dv_in = FREQ_NUM;
    else if (!cmd.mul) dv_in = {32'd0, mag_r} * 64'(WINDOW);
    else dv_in = 64'(dv_rem) * 64'(gsm_pkg::HALF_TURN_CDEG);
  end

  gsm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dv_in),
    .divisor(span_r), .done(dv_done), .quot(dv_q), .rem(dv_rem)
  );

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_r <= gsm_pkg::FREQ_LOW_RST;
      fhigh_r <= gsm_pkg::FREQ_HIGH_RST;
      plim_r <= gsm_pkg::PHASE_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsm_pkg::REG_FREQ_LOW:  flow_r <= cfg_data;
        gsm_pkg::REG_FREQ_HIGH: fhigh_r <= cfg_data;
        gsm_pkg::REG_PHASE_LIM: plim_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.load && !in_freq_level && pfl_r) ring[head_r] <= fmid;
    if (cmd.rd_old) rd_r <= ring[head_r];
    else if (cmd.rd_new) rd_r <= ring[(head_r == '0) ? LAST : head_r - 1'b1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfl_r <= 1'b0; ppl_r <= 1'b0;
      frise_r <= '0; prise_r <= '0; pmid_r <= '0;
      head_r <= '0; count_r <= '0;
      freq_r <= '0; span_r <= '0;
    end else begin
      if (cmd.load) begin
        peak_r <= in_output_peak_us;
        stop_r <= in_stop_button;
        if (in_freq_level && !pfl_r) begin
          frise_r <= in_time_us; pfl_r <= 1'b1;
        end else if (!in_freq_level && pfl_r) begin
          head_r <= (head_r == LAST) ? '0 : head_r + 1'b1;
          if (!full) count_r <= count_r + 1'b1;
          pfl_r <= 1'b0;
        end
        if (in_phase_level && !ppl_r) begin
          prise_r <= in_time_us; ppl_r <= 1'b1;
        end else if (!in_phase_level && ppl_r) begin
          pmid_r <= pmid_new; ppl_r <= 1'b0;
        end
      end
      if (cmd.rd_new) old_r <= rd_r;
      if (cmd.span) begin
        span_r <= full ? rd_r - old_r : '0;
        neg_r <= pdiff[31];
        mag_r <= pdiff[31] ? 32'd0 - pdiff : pdiff;
        freq_r <= '0;
      end
      if (dv_done && !cmd.div_sel)
        freq_r <= (dv_q > 64'(gsm_pkg::FREQ_MAX_MHZ)) ? gsm_pkg::FREQ_MAX_MHZ : dv_q[16:0];
    end
  end

  // result
  logic [15:0] ph_mag;
  logic signed [16:0] ph_s;
  logic ok;
  assign ok = full && (span_r != '0);
  assign ph_mag = ok ? dv_q[15:0] : 16'd0;
  assign ph_s = neg_r ? -$signed({1'b0, ph_mag}) : $signed({1'b0, ph_mag});

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_freq_mhz <= freq_r;
      res_freq_valid <= full;
      res_phase_cdeg <= ph_s[15:0];
      res_trip <= (ph_s > $signed({2'b0, plim_r})) || (ph_s < -$signed({2'b0, plim_r})) ||
                  (freq_r < flow_r) || (freq_r > fhigh_r) || stop_r;
    end
  end

  assign sts.div_done = dv_done;
  assign sts.full = full;
  assign sts.span_zero = (span_r == '0);

endmodule

// ===== sv/gsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsm_ctrl
// Sequencer: load, ring reads, span, three divides or none, result hand-off.
// ----------------------------------------------------------------------------
module gsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gsm_pkg::gsm_cmd_t cmd,
  input  gsm_pkg::gsm_sts_t sts
);

  localparam logic [3:0] S_IDLE = 4'd0, S_RDO = 4'd1, S_RDN = 4'd2, S_WAIT = 4'd3,
                         S_SPAN = 4'd4, S_FDIV = 4'd5, S_FRUN = 4'd6, S_RDIV = 4'd7,
                         S_RRUN = 4'd8, S_PDIV = 4'd9, S_PRUN = 4'd10, S_FIN = 4'd11,
                         S_OUT = 4'd12;

  logic [3:0] st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    in_ready = (st_r == S_IDLE);
    out_valid = (st_r == S_OUT);
    unique case (st_r)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; st_nxt = S_RDO; end
      S_RDO:  begin cmd.rd_old = 1'b1; st_nxt = S_RDN; end
      S_RDN:  begin cmd.rd_new = 1'b1; st_nxt = S_WAIT; end
      S_WAIT: st_nxt = S_SPAN;
      S_SPAN: begin cmd.span = 1'b1; st_nxt = S_FDIV; end
      S_FDIV: begin
        if (sts.full && !sts.span_zero) begin
          cmd.div_start = 1'b1; st_nxt = S_FRUN;
        end else st_nxt = S_FIN;
      end
      S_FRUN: if (sts.div_done) st_nxt = S_RDIV;
      S_RDIV: begin cmd.div_sel = 1'b1; cmd.div_start = 1'b1; st_nxt = S_RRUN; end
      S_RRUN: begin cmd.div_sel = 1'b1; if (sts.div_done) st_nxt = S_PDIV; end
      S_PDIV: begin
        cmd.div_sel = 1'b1; cmd.mul = 1'b1; cmd.div_start = 1'b1; st_nxt = S_PRUN;
      end
      S_PRUN: begin cmd.div_sel = 1'b1; if (sts.div_done) st_nxt = S_FIN; end
      S_FIN:  begin cmd.div_sel = 1'b1; cmd.fin = 1'b1; st_nxt = S_OUT; end
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  a_one_hand: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("accept and deliver overlap");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n) cmd.fin |=> out_valid)
    else $error("result not presented");
  a_load: assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.rd_old)
    else $error("load not followed by read");

endmodule

// ===== test/gsm_checker.sv =====
// ----------------------------------------------------------------------------
// gsm_checker
// Watches the item and result channels of grid_sync_monitor, predicts each
// reading from the accepted items and the limits written, and compares.
// ----------------------------------------------------------------------------
module gsm_checker #(
  parameter int WINDOW = gsm_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_freq_level,
  input  logic               in_phase_level,
  input  logic [31:0]        in_time_us,
  input  logic [31:0]        in_output_peak_us,
  input  logic               in_stop_button,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [16:0]        out_freq_mhz,
  input  logic               out_freq_valid,
  input  logic signed [15:0] out_phase_cdeg,
  input  logic               out_trip,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int RING_LEN = WINDOW + 1;

  typedef struct {
    logic [16:0]        freq_mhz;
    logic               freq_valid;
    logic signed [15:0] phase_cdeg;
    logic               trip;
  } reading_t;

  reading_t readings_due[$];

  logic [16:0] lim_freq_low, lim_freq_high;
  logic [14:0] lim_phase;

  logic        fl_prev, pl_prev;
  logic [31:0] fl_rise, pl_rise, pl_mid;
  logic [31:0] mid_ring [RING_LEN];
  int          ring_wr, ring_fill;
  logic [16:0] freq_now;
  logic [31:0] span_now;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic predict_reading(input logic fl, input logic pl, input logic [31:0] now,
                                 input logic [31:0] peak, input logic stop,
                                 output reading_t rd);
    logic [31:0] newest, oldest, d, mag;
    logic [63:0] quot, rem, cdeg;
    logic        full, neg;
    int          phase;
    phase = 0;
    if (fl && !fl_prev) begin
      fl_rise = now;
      fl_prev = 1'b1;
    end else if (!fl && fl_prev) begin
      mid_ring[ring_wr] = fl_rise + ((now - fl_rise) >> 1);
      ring_wr = (ring_wr == RING_LEN - 1) ? 0 : ring_wr + 1;
      if (ring_fill < RING_LEN) ring_fill++;
      fl_prev = 1'b0;
    end
    full = (ring_fill >= RING_LEN);
    if (full) begin
      newest   = mid_ring[(ring_wr == 0) ? RING_LEN - 1 : ring_wr - 1];
      oldest   = mid_ring[ring_wr];
      span_now = newest - oldest;
      if (span_now == 0) begin
        freq_now = '0;
      end else begin
        quot     = (64'(WINDOW) * 64'd500_000_000) / 64'(span_now);
        freq_now = (quot > 64'd100_000) ? 17'd100_000 : quot[16:0];
      end
    end else begin
      span_now = '0;
      freq_now = '0;
    end
    if (pl && !pl_prev) begin
      pl_rise = now;
      pl_prev = 1'b1;
    end else if (!pl && pl_prev) begin
      pl_mid  = pl_rise + ((now - pl_rise) >> 1);
      pl_prev = 1'b0;
    end
    if (full && span_now != 0) begin
      d     = pl_mid - peak;
      neg   = d[31];
      mag   = neg ? (32'd0 - d) : d;
      rem   = (64'(mag) * 64'(WINDOW)) % 64'(span_now);
      cdeg  = (rem * 64'd18000) / 64'(span_now);
      phase = neg ? -int'(cdeg) : int'(cdeg);
    end
    rd.freq_mhz   = freq_now;
    rd.freq_valid = full;
    rd.phase_cdeg = phase[15:0];
    rd.trip = (phase > int'(lim_phase)) || (phase < -int'(lim_phase)) ||
              (freq_now < lim_freq_low) || (freq_now > lim_freq_high) || stop;
  endtask

  always @(posedge clk) begin
    reading_t want, fresh;
    if (!rst_n) begin
      lim_freq_low  = gsm_pkg::FREQ_LOW_RST;
      lim_freq_high = gsm_pkg::FREQ_HIGH_RST;
      lim_phase     = gsm_pkg::PHASE_LIM_RST;
      fl_prev = 1'b0;  pl_prev = 1'b0;
      fl_rise = '0;    pl_rise = '0;   pl_mid = '0;
      ring_wr = 0;     ring_fill = 0;
      freq_now = '0;   span_now = '0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gsm_pkg::REG_FREQ_LOW:  lim_freq_low  = cfg_data;
          gsm_pkg::REG_FREQ_HIGH: lim_freq_high = cfg_data;
          gsm_pkg::REG_PHASE_LIM: lim_phase     = cfg_data[14:0];
          default: ;
        endcase
      end
      // Compare before predicting: a reading leaving now belongs to an older item.
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          $error("reading with no item waiting: freq_mhz %0d phase_cdeg %0d",
                 out_freq_mhz, out_phase_cdeg);
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          if (out_freq_mhz !== want.freq_mhz) begin
            $error("freq_mhz: expected %0d, got %0d", want.freq_mhz, out_freq_mhz);
            fail_count++;
          end
          if (out_freq_valid !== want.freq_valid) begin
            $error("freq_valid: expected %0d, got %0d", want.freq_valid, out_freq_valid);
            fail_count++;
          end
          if (out_phase_cdeg !== want.phase_cdeg) begin
            $error("phase_cdeg: expected %0d, got %0d", want.phase_cdeg, out_phase_cdeg);
            fail_count++;
          end
          if (out_trip !== want.trip) begin
            $error("trip: expected %0d, got %0d", want.trip, out_trip);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_reading(in_freq_level, in_phase_level, in_time_us, in_output_peak_us,
                        in_stop_button, fresh);
        readings_due.push_back(fresh);
      end
    end
    pending <= readings_due.size();
  end

endmodule

// ===== test/tb_grid_sync_monitor.sv =====
// ----------------------------------------------------------------------------
// tb_grid_sync_monitor
// Drives comparator pulse trains into grid_sync_monitor through several idle
// and limit settings; gsm_checker predicts and compares every reading.
// ----------------------------------------------------------------------------
module tb_grid_sync_monitor;

  localparam logic [1:0] REG_UNUSED = 2'd3;   // no register here, write is dropped
  localparam int         QUIET_MAX  = 20000;  // cycles without any handshake
  localparam int         SETTLE     = 250;    // above the full-ring latency
  localparam int         HOLD_LEN   = 3000;

  typedef enum {PER_NOMINAL, PER_SLOW, PER_FAST, PER_WILD} period_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_freq_level = 1'b0;
  logic               in_phase_level = 1'b0;
  logic [31:0]        in_time_us = '0;
  logic [31:0]        in_output_peak_us = '0;
  logic               in_stop_button = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [16:0]        out_freq_mhz;
  logic               out_freq_valid;
  logic signed [15:0] out_phase_cdeg;
  logic               out_trip;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;

  int fail_count, pending;

  // Stimulus bookkeeping: level of the frequency input and the midpoints sent.
  logic        lvl_sent = 1'b0;
  logic [31:0] rise_sent;
  logic [31:0] mids_sent[$];
  int          items_sent = 0;
  bit          tx_idle = 1'b0;
  logic        rx_stall = 1'b0;
  int          idle_pct = 51;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  grid_sync_monitor dut (.*);

  gsm_checker chk (.*);

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_stall && $urandom_range(99) < idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item; return at the edge that accepts it.
  task automatic offer(input logic fl, input logic pl, input logic [31:0] now,
                       input logic [31:0] peak, input logic stop);
    bit took;
    while (tx_idle && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_freq_level     <= fl;
    in_phase_level    <= pl;
    in_time_us        <= now;
    in_output_peak_us <= peak;
    in_stop_button    <= stop;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    // track what the block sees as a closed pulse
    if (fl && !lvl_sent) begin
      rise_sent = now;
      lvl_sent  = 1'b1;
    end else if (!fl && lvl_sent) begin
      mids_sent.push_back(rise_sent + ((now - rise_sent) >> 1));
      lvl_sent = 1'b0;
    end
  endtask

  // Random phase level, peak near the sample time or anywhere, rare stop.
  task automatic sample(input logic fl, input logic [31:0] now);
    logic [31:0] peak;
    int          pick;
    pick = $urandom_range(9);
    if (pick < 7) peak = now + $urandom_range(8000) - 32'd4000;
    else          peak = $urandom;
    offer(fl, 1'($urandom_range(1)), now, peak, $urandom_range(19) == 0);
  endtask

  // Hold the input, wait for every reading, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limits(input logic [16:0] lo, input logic [16:0] hi,
                              input logic [16:0] lim);
    cfg_we <= 1'b1; cfg_index <= gsm_pkg::REG_FREQ_LOW;  cfg_data <= lo;
    @(posedge clk);
    cfg_index <= gsm_pkg::REG_FREQ_HIGH; cfg_data <= hi;
    @(posedge clk);
    cfg_index <= gsm_pkg::REG_PHASE_LIM; cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pulse trains with random content; the period style changes by segment.
  logic [31:0]  t_now;
  period_mode_t seg_mode;
  int           seg_left = 0;

  task automatic run_pulses(input int n);
    int          stop_at, pick;
    logic [31:0] per, wid, t_mid;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if (seg_left == 0) begin
        pick = $urandom_range(9);
        seg_mode = (pick < 5) ? PER_NOMINAL : (pick < 6) ? PER_SLOW :
                   (pick < 8) ? PER_FAST : PER_WILD;
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      if (mids_sent.size() >= gsm_pkg::WINDOW_DEF && $urandom_range(39) == 0) begin
        // zero-width pulse on the oldest midpoint: newest equals oldest, span zero
        t_mid = mids_sent[mids_sent.size() - gsm_pkg::WINDOW_DEF];
        sample(1'b1, t_mid);
        sample(1'b0, t_mid);
      end else begin
        case (seg_mode)
          PER_NOMINAL: per = $urandom_range(9500, 10500);
          PER_SLOW:    per = $urandom_range(25000, 60000);
          PER_FAST:    per = $urandom_range(40);
          default:     per = $urandom;
        endcase
        wid = (per >> 1) + $urandom_range(3) - 32'd1;
        sample(1'b1, t_now);
        if ($urandom_range(9) == 0) sample(1'b1, t_now + (wid >> 1));
        sample(1'b0, t_now + wid);
        if ($urandom_range(9) == 0) sample(1'b0, t_now + wid + 32'd1);
        t_now = t_now + per;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits stand; an unused index must change nothing.
    cfg_we <= 1'b1; cfg_index <= REG_UNUSED; cfg_data <= 17'h1FFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, wrapped and zero-length pulses, stop pressed.
    offer(1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    offer(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer(1'b0, 1'b0, 32'h0000_0009, 32'h0000_0000, 1'b0);
    offer(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    offer(1'b1, 1'b1, 32'h8000_0100, 32'h0000_0000, 1'b1);
    offer(1'b0, 1'b1, 32'h8000_0200, 32'h8000_0000, 1'b0);
    offer(1'b0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    offer(1'b1, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    offer(1'b0, 1'b0, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0);

    t_now = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        1: write_limits(17'd0, 17'h1FFFF, 17'h1FFFF);
        2: write_limits(17'd0, 17'd0, 17'd0);
        3: write_limits(17'd48000, 17'd52000, 17'd2000);
        4: write_limits(17'($urandom_range(100000)), 17'($urandom_range(100000)),
                        17'($urandom_range(18000)));
        5: write_limits(17'd100000, 17'd100000, 17'd18000);
        default: ;
      endcase
      case (ph)
        1:       begin tx_idle = 1'b1; idle_pct = 51; rx_stall <= 1'b0; end
        2:       begin tx_idle = 1'b0; idle_pct = 51; rx_stall <= 1'b1; end
        3, 4:    begin tx_idle = 1'b1; idle_pct = 37; rx_stall <= 1'b1; end
        default: begin tx_idle = 1'b0; idle_pct = 51; rx_stall <= 1'b0; end
      endcase
      if (ph == 4) begin
        run_pulses(20);
        // long receiver hold-off while items keep coming: fill the block
        hold_req <= ~hold_req;
      end
      run_pulses(ph == 0 ? 116 : 125);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gsm_pkg.sv
sv/gsm_div.sv
sv/gsm_dp.sv
sv/gsm_ctrl.sv
sv/grid_sync_monitor.sv
test/gsm_checker.sv
test/tb_grid_sync_monitor.sv
